### rtl/kpr_pkg.sv
// Shared types, constants and helper functions of the Kermit packet receiver.
`default_nettype none
package kpr_pkg;

  localparam int unsigned MAX_PAD  = 58;
  localparam int unsigned NAME_LEN = 31;

  localparam logic [7:0] SOH_CHAR   = 8'h01;
  localparam logic [7:0] ABORT_CHAR = 8'h03;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] QUOTE_DEF  = 8'h23;
  localparam logic [7:0] TYPE_S     = 8'h53;
  localparam logic [7:0] TYPE_D     = 8'h44;
  localparam logic [7:0] TYPE_F     = 8'h46;
  localparam logic [7:0] TYPE_B     = 8'h42;
  localparam logic [7:0] TYPE_ACK   = 8'h59;
  localparam logic [7:0] TYPE_NAK   = 8'h4E;
  // Sum of the fixed length, type and data bytes of the send-init acknowledgment.
  localparam logic [7:0] INIT_SUM   = 8'(997);
  localparam logic [5:0] INIT_LAST  = 6'd18;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_REPLY  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ACKED  = 3'd0,
    ST_BREAK  = 3'd1,
    ST_INIT   = 3'd2,
    ST_NAK    = 3'd3,
    ST_ABORT  = 3'd4,
    ST_REWIND = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_LEN  = 4'd1,
    PH_SEQ  = 4'd2,
    PH_TYPE = 4'd3,
    PH_LX1  = 4'd4,
    PH_LX2  = 4'd5,
    PH_HCHK = 4'd6,
    PH_DATA = 4'd7,
    PH_CHK  = 4'd8,
    PH_END  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_SHORT  = 2'd1,
    CMD_INIT   = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    kind_t      kind;
    logic [7:0] value;
    status_t    code;
    logic [7:0] seq;
    logic [5:0] pad_count;
    logic [7:0] pad_char;
    logic [7:0] line_end;
    logic [7:0] check;
  } cmd_t;

  function automatic logic [7:0] tochr(input logic [7:0] x);
    tochr = x + 8'h20;
  endfunction

  function automatic logic [7:0] unchr(input logic [7:0] x);
    unchr = x - 8'h20;
  endfunction

  function automatic logic [7:0] check_char(input logic [7:0] s);
    logic [7:0] t;
    t = s + {6'd0, s[7:6]};
    check_char = tochr({2'b00, t[5:0]});
  endfunction

  function automatic logic [7:0] unquote(input logic [7:0] c);
    if ((c & 8'h60) == 8'h40) unquote = c & 8'hBF;
    else if ((c & 8'h7F) == 8'h3F) unquote = c | 8'h40;
    else unquote = c;
  endfunction

  // Byte of the send-init acknowledgment line by position, SOH through check.
  function automatic logic [7:0] init_byte(input logic [5:0] idx, input logic [7:0] sq,
                                           input logic [7:0] chk);
    case (idx)
      6'd0:    init_byte = SOH_CHAR;
      6'd1:    init_byte = 8'h30;
      6'd2:    init_byte = sq;
      6'd3:    init_byte = 8'h59;
      6'd4:    init_byte = 8'h7E;
      6'd5:    init_byte = 8'h23;
      6'd6:    init_byte = 8'h20;
      6'd7:    init_byte = 8'h40;
      6'd8:    init_byte = 8'h2D;
      6'd9:    init_byte = 8'h23;
      6'd10:   init_byte = 8'h4E;
      6'd11:   init_byte = 8'h31;
      6'd12:   init_byte = 8'h4E;
      6'd13:   init_byte = 8'h22;
      6'd14:   init_byte = 8'h20;
      6'd15:   init_byte = 8'h7E;
      6'd16:   init_byte = 8'h7E;
      default: init_byte = chk;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/kpr_if.sv
// Valid/ready channel interfaces for received bytes and result items.
`default_nettype none
interface kpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface kpr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [2:0] status_code;
  logic       last;
  modport source (output valid, output kind, output value, output status_code,
                  output last, input ready);
  modport sink (input valid, input kind, input value, input status_code,
                input last, output ready);
endinterface
`default_nettype wire

### rtl/kermit_packet_receiver.sv
// Kermit packet receiver top level: parser, command queue and result emitter.
//
// Channel rx carries one received line byte per transaction; channel res carries
// result items (data byte, filename byte, reply line byte or status) with a
// last flag on the final item caused by each byte.
// The parser takes one byte per cycle and reacts within that cycle; every byte
// that causes results places one command in a two-entry queue.
// The emitter expands a command into its items at one item per cycle: a
// status, data or filename result is one item, an ACK or NAK line is 6 items
// plus up to 58 pad characters, and a send-init acknowledgment is 19 items.
// When the emitter is idle, the first item of a command appears once the queue
// has registered the command and the emitter has loaded it from the queue head.
// Bytes that cause no result pass at one per cycle; the rate is set by the
// emitter when reply lines are in flight, since the parser holds while the
// queue is full.
// Synchronous reset returns the parser to hunting for SOH with default
// settings and empties the queue and emitter.
// When the result receiver stalls, the current item holds and the queue fills,
// after which rx ready drops until room frees up.
`default_nettype none
module kermit_packet_receiver (
  input  wire logic clk,
  input  wire logic rst,
  kpr_rx_if.sink    rx,
  kpr_res_if.source res
);

  kpr_pkg::cmd_t cmd;
  kpr_pkg::cmd_t head;
  logic          cmd_push;
  logic          full;
  logic          not_empty;
  logic          pop;
  logic          in_fire;

  assign rx.ready = !full;
  assign in_fire  = rx.valid && rx.ready;

  kpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .b        (rx.rx_byte),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  kpr_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && cmd_push),
    .push_cmd  (cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  kpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (not_empty),
    .head      (head),
    .pop       (pop),
    .res       (res)
  );

endmodule
`default_nettype wire

### rtl/kpr_front.sv
// Packet parser: tracks protocol state per byte and issues reply commands.
`default_nettype none
module kpr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic [7:0]     b,
  output kpr_pkg::cmd_t       cmd,
  output logic                cmd_push
);

  kpr_pkg::phase_t phase, phase_next;
  logic [13:0] remaining_length, remaining_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  sequence_number, sequence_number_next;
  logic [8:0]  previous_sequence, previous_sequence_next;
  logic [7:0]  packet_type, packet_type_next;
  logic        escape_pending, escape_pending_next;
  logic        escape_checkpoint, escape_checkpoint_next;
  logic [5:0]  pad_count, pad_count_next;
  logic [7:0]  pad_character, pad_character_next;
  logic [7:0]  line_end, line_end_next;
  logic [7:0]  quote_character, quote_character_next;
  logic [4:0]  name_index, name_index_next;
  logic [3:0]  field_index, field_index_next;
  logic [6:0]  length_high, length_high_next;

  logic        printable;
  logic [7:0]  expect_chk;
  logic [7:0]  ub;
  logic [7:0]  sq_chr;
  logic [13:0] ext_len;

  assign printable  = (b[7:5] != 3'b000);
  assign expect_chk = kpr_pkg::check_char(running_sum);
  assign ub         = kpr_pkg::unchr(b);
  assign sq_chr     = kpr_pkg::tochr(sequence_number);
  assign ext_len    = {7'd0, length_high} * 14'd95 + {7'd0, ub[6:0]};

  always_comb begin
    phase_next = phase;
    unique case (phase)
      kpr_pkg::PH_HUNT: if (b == kpr_pkg::SOH_CHAR) phase_next = kpr_pkg::PH_LEN;
      kpr_pkg::PH_LEN:  phase_next = printable ? kpr_pkg::PH_SEQ : kpr_pkg::PH_HUNT;
      kpr_pkg::PH_SEQ:  phase_next = printable ? kpr_pkg::PH_TYPE : kpr_pkg::PH_HUNT;
      kpr_pkg::PH_TYPE: begin
        if (!printable) phase_next = kpr_pkg::PH_HUNT;
        else if (remaining_length == '0) phase_next = kpr_pkg::PH_LX1;
        else if (remaining_length > 14'd3) phase_next = kpr_pkg::PH_DATA;
        else phase_next = kpr_pkg::PH_CHK;
      end
      kpr_pkg::PH_LX1:  phase_next = printable ? kpr_pkg::PH_LX2 : kpr_pkg::PH_HUNT;
      kpr_pkg::PH_LX2:  phase_next = printable ? kpr_pkg::PH_HCHK : kpr_pkg::PH_HUNT;
      kpr_pkg::PH_HCHK: begin
        if (!printable || b != expect_chk) phase_next = kpr_pkg::PH_HUNT;
        else if (remaining_length > 14'd1) phase_next = kpr_pkg::PH_DATA;
        else phase_next = kpr_pkg::PH_CHK;
      end
      kpr_pkg::PH_DATA: begin
        if (!printable) phase_next = kpr_pkg::PH_HUNT;
        else if (remaining_length <= 14'd1) phase_next = kpr_pkg::PH_CHK;
      end
      kpr_pkg::PH_CHK:
        phase_next = (printable && b == expect_chk) ? kpr_pkg::PH_END : kpr_pkg::PH_HUNT;
      kpr_pkg::PH_END:  phase_next = kpr_pkg::PH_HUNT;
      default:          phase_next = kpr_pkg::PH_HUNT;
    endcase
  end

  always_comb begin
    logic fault;
    logic dstart;
    logic [7:0] ptype;
    fault = 1'b0;
    dstart = 1'b0;
    ptype = packet_type;
    remaining_length_next  = remaining_length;
    running_sum_next       = running_sum + b;
    sequence_number_next   = sequence_number;
    previous_sequence_next = previous_sequence;
    packet_type_next       = packet_type;
    escape_pending_next    = escape_pending;
    escape_checkpoint_next = escape_checkpoint;
    pad_count_next         = pad_count;
    pad_character_next     = pad_character;
    line_end_next          = line_end;
    quote_character_next   = quote_character;
    name_index_next        = name_index;
    field_index_next       = field_index;
    length_high_next       = length_high;
    cmd_push               = 1'b0;
    cmd.op        = kpr_pkg::CMD_STATUS;
    cmd.kind      = kpr_pkg::KIND_STATUS;
    cmd.value     = packet_type;
    cmd.code      = kpr_pkg::ST_ABORT;
    cmd.seq       = sq_chr;
    cmd.pad_count = pad_count;
    cmd.pad_char  = pad_character;
    cmd.line_end  = line_end;
    cmd.check     = '0;

    unique case (phase)
      kpr_pkg::PH_HUNT: begin
        running_sum_next = running_sum;
        if (b == kpr_pkg::ABORT_CHAR) cmd_push = 1'b1;
        else if (b == kpr_pkg::SOH_CHAR) running_sum_next = '0;
      end
      kpr_pkg::PH_LEN: begin
        if (!printable) fault = 1'b1;
        else remaining_length_next = {6'd0, ub};
      end
      kpr_pkg::PH_SEQ: begin
        if (!printable) fault = 1'b1;
        else begin
          sequence_number_next = ub;
          if (previous_sequence == {1'b0, ub}) begin
            escape_pending_next = escape_checkpoint;
            cmd_push  = 1'b1;
            cmd.code  = kpr_pkg::ST_REWIND;
          end else begin
            previous_sequence_next = {1'b0, ub};
            escape_checkpoint_next = escape_pending;
          end
        end
      end
      kpr_pkg::PH_TYPE: begin
        if (!printable) fault = 1'b1;
        else begin
          packet_type_next = b;
          ptype = b;
          if (remaining_length != '0) begin
            remaining_length_next = (remaining_length >= 14'd3) ?
                                    remaining_length - 14'd3 : '0;
            dstart = 1'b1;
          end
        end
      end
      kpr_pkg::PH_LX1: begin
        if (!printable) fault = 1'b1;
        else length_high_next = ub[6:0];
      end
      kpr_pkg::PH_LX2: begin
        if (!printable) fault = 1'b1;
        else remaining_length_next = ext_len;
      end
      kpr_pkg::PH_HCHK: begin
        if (!printable || b != expect_chk) fault = 1'b1;
        else begin
          if (remaining_length != '0) remaining_length_next = remaining_length - 14'd1;
          dstart = 1'b1;
        end
      end
      kpr_pkg::PH_DATA: begin
        if (!printable) fault = 1'b1;
        else begin
          if (remaining_length != '0) remaining_length_next = remaining_length - 14'd1;
          if (packet_type == kpr_pkg::TYPE_D || packet_type == kpr_pkg::TYPE_F) begin
            cmd.code  = kpr_pkg::ST_ACKED;
            cmd.value = b;
            if (escape_pending) begin
              cmd.value = kpr_pkg::unquote(b);
              escape_pending_next = 1'b0;
              cmd_push = 1'b1;
            end else if (b == quote_character) begin
              escape_pending_next = 1'b1;
            end else begin
              cmd_push = 1'b1;
            end
            if (cmd_push) begin
              if (packet_type == kpr_pkg::TYPE_F && name_index < 5'(kpr_pkg::NAME_LEN)) begin
                name_index_next = name_index + 5'd1;
                cmd.kind = kpr_pkg::KIND_NAME;
              end else begin
                cmd.kind = kpr_pkg::KIND_DATA;
              end
            end
          end else if (packet_type == kpr_pkg::TYPE_S) begin
            case (field_index)
              4'd2: pad_count_next = (ub > 8'(kpr_pkg::MAX_PAD)) ?
                                     6'(kpr_pkg::MAX_PAD) : ub[5:0];
              4'd3: pad_character_next = kpr_pkg::unquote(b);
              4'd4: line_end_next = ub;
              4'd5: quote_character_next = b;
              default: ;
            endcase
            if (field_index != 4'd15) field_index_next = field_index + 4'd1;
          end
        end
      end
      kpr_pkg::PH_CHK: begin
        if (!printable || b != expect_chk) fault = 1'b1;
      end
      kpr_pkg::PH_END: begin
        if (b != kpr_pkg::CR_CHAR) fault = 1'b1;
        else begin
          cmd_push = 1'b1;
          if (packet_type == kpr_pkg::TYPE_S) begin
            cmd.op    = kpr_pkg::CMD_INIT;
            cmd.code  = kpr_pkg::ST_INIT;
            cmd.check = kpr_pkg::check_char(kpr_pkg::INIT_SUM + sq_chr);
          end else begin
            cmd.op    = kpr_pkg::CMD_SHORT;
            cmd.value = kpr_pkg::TYPE_ACK;
            cmd.code  = (packet_type == kpr_pkg::TYPE_B) ? kpr_pkg::ST_BREAK :
                        kpr_pkg::ST_ACKED;
            cmd.check = kpr_pkg::check_char(8'h23 + sq_chr + kpr_pkg::TYPE_ACK);
          end
        end
      end
      default: ;
    endcase

    if (dstart) begin
      name_index_next  = '0;
      field_index_next = '0;
      if (ptype == kpr_pkg::TYPE_S) begin
        pad_count_next       = '0;
        pad_character_next   = '0;
        line_end_next        = kpr_pkg::CR_CHAR;
        quote_character_next = kpr_pkg::QUOTE_DEF;
      end
    end

    if (fault) begin
      escape_pending_next = escape_checkpoint;
      cmd_push  = 1'b1;
      cmd.op    = kpr_pkg::CMD_SHORT;
      cmd.value = kpr_pkg::TYPE_NAK;
      cmd.code  = kpr_pkg::ST_NAK;
      cmd.line_end = line_end;
      cmd.check = kpr_pkg::check_char(8'h23 + sq_chr + kpr_pkg::TYPE_NAK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= kpr_pkg::PH_HUNT;
      remaining_length  <= '0;
      running_sum       <= '0;
      sequence_number   <= '0;
      previous_sequence <= 9'h100;
      packet_type       <= '0;
      escape_pending    <= 1'b0;
      escape_checkpoint <= 1'b0;
      pad_count         <= '0;
      pad_character     <= '0;
      line_end          <= kpr_pkg::CR_CHAR;
      quote_character   <= kpr_pkg::QUOTE_DEF;
      name_index        <= '0;
      field_index       <= '0;
      length_high       <= '0;
    end else if (in_fire) begin
      phase             <= phase_next;
      remaining_length  <= remaining_length_next;
      running_sum       <= running_sum_next;
      sequence_number   <= sequence_number_next;
      previous_sequence <= previous_sequence_next;
      packet_type       <= packet_type_next;
      escape_pending    <= escape_pending_next;
      escape_checkpoint <= escape_checkpoint_next;
      pad_count         <= pad_count_next;
      pad_character     <= pad_character_next;
      line_end          <= line_end_next;
      quote_character   <= quote_character_next;
      name_index        <= name_index_next;
      field_index       <= field_index_next;
      length_high       <= length_high_next;
    end
  end

endmodule
`default_nettype wire

### rtl/kpr_cmd_fifo.sv
// Two-entry command queue between the parser and the result emitter.
`default_nettype none
module kpr_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire kpr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output kpr_pkg::cmd_t      head
);

  kpr_pkg::cmd_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/kpr_back.sv
// Result emitter: expands one command into its sequence of result items.
`default_nettype none
module kpr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire kpr_pkg::cmd_t head,
  output logic               pop,
  kpr_res_if.source          res
);

  kpr_pkg::cmd_t cur;
  logic          busy;
  logic [5:0]    step;
  logic [5:0]    rel;
  logic          is_last;
  logic          fire;

  assign fire = res.valid && res.ready;
  assign rel  = step - cur.pad_count;
  assign pop  = cmd_valid && (!busy || (fire && is_last));

  always_comb begin
    res.valid       = busy;
    res.status_code = cur.code;
    res.kind        = kpr_pkg::KIND_REPLY;
    res.value       = '0;
    is_last         = 1'b0;
    unique case (cur.op)
      kpr_pkg::CMD_STATUS: begin
        is_last = 1'b1;
        res.value = cur.value;
        // Status, data and filename results are single items; the kind comes along.
        res.kind = cur.kind;
      end
      kpr_pkg::CMD_SHORT: begin
        if (step < cur.pad_count) res.value = cur.pad_char;
        else begin
          case (rel[2:0])
            3'd0:    res.value = kpr_pkg::SOH_CHAR;
            3'd1:    res.value = 8'h23;
            3'd2:    res.value = cur.seq;
            3'd3:    res.value = cur.value;
            3'd4:    res.value = cur.check;
            default: res.value = cur.line_end;
          endcase
          is_last = (rel[2:0] == 3'd5);
        end
      end
      kpr_pkg::CMD_INIT: begin
        if (step == kpr_pkg::INIT_LAST) begin
          res.value = cur.line_end;
          is_last = 1'b1;
        end else begin
          res.value = kpr_pkg::init_byte(step, cur.seq, cur.check);
        end
      end
      default: is_last = 1'b1;
    endcase
    res.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) cur <= '0;
    else if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      step <= '0;
    end else if (fire) begin
      if (is_last) busy <= 1'b0;
      step <= step + 6'd1;
    end
  end

endmodule
`default_nettype wire
